FILE: rtl/btda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btda_pkg
// Shared constants for the binary to decimal ascii converter: value width,
// digit count and the ascii base of the digit codes.
// ----------------------------------------------------------------------------
package btda_pkg;

  // width of the value that is rendered (4 to 64)
  localparam int VALUE_BITS = 64;

  // decimal digits needed for the largest value, from log10(2) ~ 0.30103
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  localparam int BCD_W   = 4 * DIGITS;
  localparam int CNT_W   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int DCNT_W  = $clog2(DIGITS + 1);

  localparam logic [5:0] DIGIT_BASE = 6'd48;

endpackage

FILE: rtl/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Renders an unsigned binary value as ascii decimal digits, most significant
// first, no leading zeros; bit-serial shift-and-add-3 conversion.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  value[63:0]
//   out      out  out_valid/out_stall  char_code[5:0], last_digit
//
// one request passes an accept step, VALUE_BITS conversion steps (one bit of
// the value shifts into the bcd register per cycle), one skip step per leading
// zero digit plus one more to leave the skip, then one digit is emitted per
// cycle while the output is not stalled. rst is synchronous and clears the
// sequencer and the output valid. out_stall holds the output register; a new
// request can be taken while the final digit is still waiting.
//
module binary_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  char_code,
  output logic        last_digit
);

  typedef enum logic [1:0] {
    IDLE,
    CONVERT,
    SKIP,
    EMIT
  } state_t;

  state_t                               state;
  logic [btda_pkg::VALUE_BITS-1:0]      shreg;
  logic [btda_pkg::BCD_W-1:0]           bcd;
  logic [btda_pkg::BCD_W-1:0]           bcd_adj;
  logic [btda_pkg::CNT_W-1:0]           bit_cnt;
  logic [btda_pkg::DCNT_W-1:0]          dig_left;
  logic [3:0]                           top_digit;
  logic                                 in_accept;
  logic                                 out_free;

  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign top_digit = bcd[btda_pkg::BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the next shift
  always_comb begin
    for (int i = 0; i < btda_pkg::DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_accept) begin
            shreg   <= value[btda_pkg::VALUE_BITS-1:0];
            bcd     <= '0;
            bit_cnt <= btda_pkg::CNT_W'(btda_pkg::VALUE_BITS - 1);
            state   <= CONVERT;
          end
        end
        CONVERT: begin
          bcd   <= {bcd_adj[btda_pkg::BCD_W-2:0], shreg[btda_pkg::VALUE_BITS-1]};
          shreg <= shreg << 1;
          if (bit_cnt == '0) begin
            dig_left <= btda_pkg::DCNT_W'(btda_pkg::DIGITS);
            state    <= SKIP;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        SKIP: begin
          // drop leading zeros but keep at least one digit
          if (top_digit == 4'd0 && dig_left > btda_pkg::DCNT_W'(1)) begin
            bcd      <= bcd << 4;
            dig_left <= dig_left - 1'b1;
          end else begin
            state <= EMIT;
          end
        end
        EMIT: begin
          if (out_free) begin
            char_code  <= btda_pkg::DIGIT_BASE | {2'b00, top_digit};
            last_digit <= (dig_left == btda_pkg::DCNT_W'(1));
            bcd        <= bcd << 4;
            dig_left   <= dig_left - 1'b1;
            if (dig_left == btda_pkg::DCNT_W'(1)) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state == CONVERT)
    else $error("accepted request did not start conversion");

  a_digit_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_code[5:4] == 2'b11 && char_code[3:0] <= 4'd9)
    else $error("output code is not a decimal digit");

  a_emit_digit: assert property (@(posedge clk) disable iff (rst)
    state == EMIT |-> top_digit <= 4'd9 && dig_left != '0)
    else $error("emit with invalid bcd digit or no digits left");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    state == EMIT && out_free && dig_left == btda_pkg::DCNT_W'(1)
      |=> state == IDLE && out_valid && last_digit)
    else $error("final digit not flagged or sequencer not idle");

endmodule
